@@ rtl/core/rcbe_pkg.sv @@
package rcbe_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    localparam int MAX_ROUNDS = 5;
    localparam int WIDTH_SHIFT = 39;
    localparam int BYTE_SHIFT = 56;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  symbol;
        logic [8:0]  entry_index;
        logic [31:0] entry_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] repeat_count;
        logic        last_of_run;
    } out_item_t;

    // divider control between the sequencer and the bit-serial divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

endpackage

@@ rtl/core/rcbe_divider.sv @@
module rcbe_divider
    import rcbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    input  logic [31:0] divisor,
    output div_rsp_t    rsp
);

    // restoring division, one quotient bit per cycle
    logic [63:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quot_reg[63]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next  = trial - {1'b0, divisor};
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg[31:0];

endmodule

@@ rtl/core/rcbe_multiplier.sv @@
module rcbe_multiplier
    import rcbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] mcand,
    input  logic [31:0] mplier,
    output logic        done,
    output logic [63:0] product
);

    // shift-add, one multiplier bit per cycle, product modulo 2^64
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mc_reg, mc_next;
    logic [31:0] mp_reg, mp_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = mcand;
            mp_next   = mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
                acc_next = acc_reg + mc_reg;
            mc_next  = {mc_reg[62:0], 1'b0};
            mp_next  = {1'b0, mp_reg[31:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/core/range_coder_byte_encoder.sv @@
// static-model range encoder, byte output
// cfg channel: cfg_valid/cfg_ready carries total_count; write only while idle
// (zero is treated as one)
// in channel: in_valid/in_stall carries in_item; command load writes one entry
// of the cumulative table, encode narrows the interval and renormalizes,
// finish emits eight bytes of the bit-reversed midpoint, low byte first
// out channel: out_valid/out_stall carries out_item; last_of_run marks the final
// result of an input item
// one item is worked at a time; in_stall is high while an item is in progress
// or a result still sits in the output register
// loads can follow back to back; finish sends its bytes from ST_FIN, then resets in ST_FIN_OUT
// encode: two table reads, the bit-serial divider (run three times), the
// shift-add multiplier (run four times) and wrap-up; each renormalization round
// passes ST_NARROW, ST_CHECK and ST_BYTE, with ST_PEND added for a pending byte
// and ST_RUN for a run
// each encode result waits in a one-entry stage until the next one is known,
// so the final one can carry last_of_run; out_stall holds the sequencer
// reset returns the interval to [0, all ones], clears pending state and sets
// total_count to one; the table is undefined until loaded
module range_coder_byte_encoder
    import rcbe_pkg::*;
#(
    parameter int ALPHABET     = 256,
    parameter int PENDING_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    localparam int IDX_W = $clog2(ALPHABET + 1);
    localparam int PEND_W = (PENDING_BITS < 32) ? PENDING_BITS : 32;
    localparam logic [31:0] PEND_LIMIT = 32'((64'd1 << PEND_W) - 64'd1);

    // sequencer states
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_RD_KL   = 5'd1;
    localparam logic [4:0] ST_RD_KR   = 5'd2;
    localparam logic [4:0] ST_DIV_D   = 5'd3;
    localparam logic [4:0] ST_MUL_QR  = 5'd4;
    localparam logic [4:0] ST_MUL_QL  = 5'd5;
    localparam logic [4:0] ST_MUL_MR  = 5'd6;
    localparam logic [4:0] ST_DIV_MR  = 5'd7;
    localparam logic [4:0] ST_MUL_ML  = 5'd8;
    localparam logic [4:0] ST_DIV_ML  = 5'd9;
    localparam logic [4:0] ST_NARROW  = 5'd10;
    localparam logic [4:0] ST_CHECK   = 5'd11;
    localparam logic [4:0] ST_PEND    = 5'd12;
    localparam logic [4:0] ST_RUN     = 5'd13;
    localparam logic [4:0] ST_BYTE    = 5'd14;
    localparam logic [4:0] ST_EMIT    = 5'd15;
    localparam logic [4:0] ST_FIN     = 5'd16;
    localparam logic [4:0] ST_FIN_OUT = 5'd17;
    localparam logic [4:0] ST_LAST    = 5'd18;

    // cumulative count table
    logic [31:0] table_mem [ALPHABET+1];
    logic [31:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic        rd_en;

    logic [31:0] total_reg;
    logic [31:0] divisor;
    logic [4:0]  state_reg, state_next;
    logic [63:0] low_reg, low_next, high_reg, high_next;
    logic [63:0] lo_w_reg, lo_w_next, hi_w_reg, hi_w_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] q_reg, q_next;
    logic [31:0] m_reg, m_next;
    logic [31:0] kl_reg, kl_next, kr_reg, kr_next;
    logic [31:0] pend_reg, pend_next;
    logic [7:0]  sav_lo_reg, sav_lo_next, sav_hi_reg, sav_hi_next;
    logic [2:0]  rounds_reg, rounds_next;
    logic [2:0]  fin_cnt_reg, fin_cnt_next;
    logic        up_reg, up_next;
    logic [7:0]  symbol_reg, symbol_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;
    logic        stage_valid_reg, stage_valid_next;
    out_item_t   stage_reg, stage_next;
    logic        stage_ok;
    logic        emit_req;
    out_item_t   emit_item;

    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic        mul_start;
    logic [63:0] mul_mcand;
    logic [31:0] mul_mplier;
    logic        mul_done;
    logic [63:0] mul_prod;

    logic        accept;
    logic [63:0] mid;
    logic [63:0] rev;

    assign divisor   = (total_reg == 32'd0) ? 32'd1 : total_reg;
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // a new result may enter the stage if it is empty or its content can move out
    assign stage_ok  = !stage_valid_reg || !(out_valid_reg && out_stall);

    assign mid = (low_reg >> 1) + (high_reg >> 1) + {63'd0, low_reg[0] & high_reg[0]};
    always_comb
    begin
        for (int i = 0; i < 64; i++)
            rev[i] = mid[63-i];
    end

    rcbe_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (divisor),
        .rsp     (div_rsp)
    );

    rcbe_multiplier u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_prod)
    );

    // table write on load, registered read
    always_ff @(posedge clk)
    begin
        if (accept && in_item.command == CMD_LOAD &&
            {23'd0, in_item.entry_index} <= 32'(ALPHABET))
            table_mem[in_item.entry_index[IDX_W-1:0]] <= in_item.entry_value;
        if (rd_en)
            rd_data_reg <= table_mem[rd_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        lo_w_next    = lo_w_reg;
        hi_w_next    = hi_w_reg;
        d_next       = d_reg;
        q_next       = q_reg;
        m_next       = m_reg;
        kl_next      = kl_reg;
        kr_next      = kr_reg;
        pend_next    = pend_reg;
        sav_lo_next  = sav_lo_reg;
        sav_hi_next  = sav_hi_reg;
        rounds_next  = rounds_reg;
        fin_cnt_next = fin_cnt_reg;
        up_next      = up_reg;
        symbol_next  = symbol_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next     = out_reg;
        stage_valid_next = stage_valid_reg;
        stage_next   = stage_reg;
        emit_req     = 1'b0;
        emit_item    = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        div_req.start    = 1'b0;
        div_req.dividend = d_reg;
        mul_start    = 1'b0;
        mul_mcand    = q_reg;
        mul_mplier   = kr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.command == CMD_ENCODE &&
                        {24'd0, in_item.symbol} < 32'(ALPHABET))
                    begin
                        symbol_next = in_item.symbol;
                        rd_en       = 1'b1;
                        rd_addr     = IDX_W'(in_item.symbol);
                        rounds_next = '0;
                        state_next  = ST_RD_KL;
                    end
                    else if (in_item.command == CMD_FINISH)
                    begin
                        fin_cnt_next = '0;
                        state_next   = ST_FIN;
                    end
                end
            end
            ST_RD_KL:
            begin
                kl_next    = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = IDX_W'({1'b0, symbol_reg} + 9'd1);
                state_next = ST_RD_KR;
            end
            ST_RD_KR:
            begin
                kr_next = rd_data_reg;
                d_next  = high_reg - low_reg;
                div_req.start    = 1'b1;
                div_req.dividend = high_reg - low_reg;
                state_next = ST_DIV_D;
            end
            ST_DIV_D:
            begin
                if (div_rsp.done)
                begin
                    q_next = div_rsp.quotient;
                    m_next = div_rsp.remainder;
                    mul_start  = 1'b1;
                    mul_mcand  = div_rsp.quotient;
                    mul_mplier = kr_reg;
                    state_next = ST_MUL_QR;
                end
            end
            ST_MUL_QR:
            begin
                if (mul_done)
                begin
                    hi_w_next  = low_reg + mul_prod;
                    mul_start  = 1'b1;
                    mul_mcand  = q_reg;
                    mul_mplier = kl_reg;
                    state_next = ST_MUL_QL;
                end
            end
            ST_MUL_QL:
            begin
                if (mul_done)
                begin
                    lo_w_next  = low_reg + mul_prod;
                    mul_start  = 1'b1;
                    mul_mcand  = {32'd0, m_reg};
                    mul_mplier = kr_reg;
                    state_next = ST_MUL_MR;
                end
            end
            ST_MUL_MR:
            begin
                if (mul_done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_prod;
                    state_next = ST_DIV_MR;
                end
            end
            ST_DIV_MR:
            begin
                if (div_rsp.done)
                begin
                    hi_w_next  = hi_w_reg + div_rsp.quotient;
                    mul_start  = 1'b1;
                    mul_mcand  = {32'd0, m_reg};
                    mul_mplier = kl_reg;
                    state_next = ST_MUL_ML;
                end
            end
            ST_MUL_ML:
            begin
                if (mul_done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_prod;
                    state_next = ST_DIV_ML;
                end
            end
            ST_DIV_ML:
            begin
                if (div_rsp.done)
                begin
                    lo_w_next  = lo_w_reg + div_rsp.quotient;
                    state_next = ST_NARROW;
                end
            end
            ST_NARROW:
            begin
                // d_reg holds the width before narrowing or after each round
                if (d_reg[63:WIDTH_SHIFT] == '0 && rounds_reg < 3'(MAX_ROUNDS))
                    state_next = ST_CHECK;
                else
                    state_next = ST_LAST;
            end
            ST_CHECK:
            begin
                if (pend_reg != 32'd0 && (lo_w_reg[63] == hi_w_reg[63]))
                begin
                    up_next   = lo_w_reg[63];
                    lo_w_next = lo_w_reg ^ {1'b1, 63'd0};
                    hi_w_next = hi_w_reg ^ {1'b1, 63'd0};
                    state_next = ST_PEND;
                end
                else
                    state_next = ST_BYTE;
            end
            ST_PEND:
            begin
                if (stage_ok)
                begin
                    emit_req = 1'b1;
                    emit_item.out_byte     = up_reg ? sav_hi_reg : sav_lo_reg;
                    emit_item.repeat_count = 32'd1;
                    if (pend_reg > 32'd1)
                        state_next = ST_RUN;
                    else
                    begin
                        pend_next  = '0;
                        state_next = ST_BYTE;
                    end
                end
            end
            ST_RUN:
            begin
                if (stage_ok)
                begin
                    emit_req = 1'b1;
                    emit_item.out_byte     = up_reg ? 8'h00 : 8'hff;
                    emit_item.repeat_count = pend_reg - 32'd1;
                    pend_next  = '0;
                    state_next = ST_BYTE;
                end
            end
            ST_BYTE:
            begin
                if (lo_w_reg[63:BYTE_SHIFT] == hi_w_reg[63:BYTE_SHIFT])
                begin
                    if (stage_ok)
                    begin
                        emit_req = 1'b1;
                        emit_item.out_byte     = lo_w_reg[63:BYTE_SHIFT];
                        emit_item.repeat_count = 32'd1;
                        lo_w_next   = {lo_w_reg[55:0], 8'd0};
                        hi_w_next   = {hi_w_reg[55:0], 8'd0};
                        d_next      = {hi_w_reg[55:0], 8'd0} - {lo_w_reg[55:0], 8'd0};
                        rounds_next = rounds_reg + 3'd1;
                        state_next  = ST_NARROW;
                    end
                end
                else
                begin
                    if (pend_reg == 32'd0)
                    begin
                        sav_lo_next = lo_w_reg[63:BYTE_SHIFT];
                        sav_hi_next = hi_w_reg[63:BYTE_SHIFT];
                    end
                    if (pend_reg < PEND_LIMIT)
                        pend_next = pend_reg + 32'd1;
                    lo_w_next   = {lo_w_reg[55:0], 8'd0} - {1'b1, 63'd0};
                    hi_w_next   = {hi_w_reg[55:0], 8'd0} + {1'b1, 63'd0};
                    d_next      = ({hi_w_reg[55:0], 8'd0} + {1'b1, 63'd0})
                                - ({lo_w_reg[55:0], 8'd0} - {1'b1, 63'd0});
                    rounds_next = rounds_reg + 3'd1;
                    state_next  = ST_NARROW;
                end
            end
            ST_LAST:
            begin
                // commit interval, then send the staged result flagged as final
                low_next  = lo_w_reg;
                high_next = hi_w_reg;
                if (!stage_valid_reg)
                    state_next = ST_EMIT;
                else if (!out_valid_next)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = stage_reg;
                    out_next.last_of_run = 1'b1;
                    stage_valid_next     = 1'b0;
                    state_next           = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                state_next = ST_IDLE;
            end
            ST_FIN:
            begin
                if (!out_valid_next)
                begin
                    out_valid_next = 1'b1;
                    out_next.out_byte     = rev[fin_cnt_reg*8 +: 8];
                    out_next.repeat_count = 32'd1;
                    out_next.last_of_run  = (fin_cnt_reg == 3'd7);
                    fin_cnt_next = fin_cnt_reg + 3'd1;
                    if (fin_cnt_reg == 3'd7)
                        state_next = ST_FIN_OUT;
                end
            end
            ST_FIN_OUT:
            begin
                low_next    = '0;
                high_next   = '1;
                pend_next   = '0;
                sav_lo_next = '0;
                sav_hi_next = '0;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // new result goes to the stage, the staged one moves to the output
        if (emit_req)
        begin
            if (stage_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = stage_reg;
            end
            stage_next       = emit_item;
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            total_reg       <= 32'd1;
            low_reg         <= '0;
            high_reg        <= '1;
            pend_reg        <= '0;
            sav_lo_reg      <= '0;
            sav_hi_reg      <= '0;
            out_valid_reg   <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
            pend_reg        <= pend_next;
            sav_lo_reg      <= sav_lo_next;
            sav_hi_reg      <= sav_hi_next;
            out_valid_reg   <= out_valid_next;
            stage_valid_reg <= stage_valid_next;
            if (cfg_valid && cfg_ready)
                total_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_w_reg    <= lo_w_next;
        hi_w_reg    <= hi_w_next;
        d_reg       <= d_next;
        q_reg       <= q_next;
        m_reg       <= m_next;
        kl_reg      <= kl_next;
        kr_reg      <= kr_next;
        rounds_reg  <= rounds_next;
        fin_cnt_reg <= fin_cnt_next;
        up_reg      <= up_next;
        symbol_reg  <= symbol_next;
        out_reg     <= out_next;
        stage_reg   <= stage_next;
    end

endmodule
